### sv/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;

	localparam int MAX_SEGMENTS     = 64;
	localparam int MAX_RINGS        = 64;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RINGS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THETA_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_STEP   = 3'd4;

	localparam logic OP_VERTEX   = 1'b0;
	localparam logic OP_TRIANGLE = 1'b1;

	localparam logic signed [15:0] NORM_ONE = 16'sd16384;

	typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

	// quarter-wave folded taylor series to x^11 in unsigned q30, rounded to q14
	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		longint unsigned d, n, q, r, x, x2, t, s, m;
		d = longint'(SINE_TABLE_DEPTH);
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			n = longint'(k) * 4;
			q = n >> SINE_AW;
			r = n - q * d;
			if (q[0])
				r = d - r;
			x  = (r * 64'd1686629713) >> SINE_AW;
			x2 = (x * x) >> 30;
			t  = 64'd1073741824 - x2 / 110;
			t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
			t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
			t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
			t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			m  = (s + 64'd32768) >> 16;
			if (m > 64'd16384)
				m = 64'd16384;
			tab[k] = (q >= 2) ? -$signed(m[15:0]) : $signed(m[15:0]);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	// shift right with rounding half away from zero
	function automatic logic signed [33:0] round_away(input logic signed [33:0] v,
			input int unsigned sh);
		logic [33:0] mag;
		logic [33:0] m;
		mag = v[33] ? 34'(-v) : 34'(v);
		m   = (mag + (34'd1 << (sh - 1))) >> sh;
		return v[33] ? -$signed(m) : $signed(m);
	endfunction

	// element data that travels alongside the arithmetic
	typedef struct packed {
		logic        valid_res;
		logic        vert;
		logic        pole_n;
		logic        pole_s;
		logic [11:0] vertex_index;
		logic [11:0] tri_a;
		logic [11:0] tri_b;
		logic [11:0] tri_c;
	} carry_t;

endpackage

### sv/uvs_if.sv
`timescale 1ns / 1ps
interface uvs_req_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [5:0] row;
	logic [5:0] column;
	logic       half;

	modport source (output valid, operation, row, column, half, input ready);
	modport sink (input valid, operation, row, column, half, output ready);
endinterface

interface uvs_res_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic        [11:0] vertex_index;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic        [11:0] tri_index_a;
	logic        [11:0] tri_index_b;
	logic        [11:0] tri_index_c;

	modport source (output valid, valid_res, vertex_index, pos_x, pos_y, pos_z,
		norm_x, norm_y, norm_z, tri_index_a, tri_index_b, tri_index_c, input ready);
	modport sink (input valid, valid_res, vertex_index, pos_x, pos_y, pos_z,
		norm_x, norm_y, norm_z, tri_index_a, tri_index_b, tri_index_c, output ready);
endinterface

interface uvs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/uv_sphere_vertex_and_index_gen_top.sv
`timescale 1ns / 1ps
// UV sphere element generator: each request names a vertex (row, column) or a triangle
// (band, column, half) and returns one result. Vertex results carry the buffer index,
// position and unit normal; triangle results carry three vertex indices; a request naming
// nothing that exists returns valid_res low with all fields zero. One request is taken per
// cycle while the output is free or taken, and passes in order through the four pipeline
// stages (angle and index multiply, sine table read, normal multiply, radius multiply).
// When the result is not taken every stage holds. Configuration writes are always taken,
// but must only be made while no request is in flight.
module uv_sphere_vertex_and_index_gen_top
	import uvs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	uvs_cfg_if.sink         cfg,
	uvs_req_if.sink         req,
	uvs_res_if.source       res
);

	logic [6:0]  segments_q;
	logic [6:0]  rings_q;
	logic [15:0] radius_q;
	logic [15:0] theta_step_q;
	logic [15:0] phi_step_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q   <= 7'd32;
			rings_q      <= 7'd16;
			radius_q     <= 16'd4096;
			theta_step_q <= 16'd2185;
			phi_step_q   <= 16'd2114;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SEGMENTS:   segments_q   <= cfg.data[6:0];
				REG_RINGS:      rings_q      <= cfg.data[6:0];
				REG_RADIUS:     radius_q     <= cfg.data;
				REG_THETA_STEP: theta_step_q <= cfg.data;
				REG_PHI_STEP:   phi_step_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline control: whole pipe advances while the output slot is free or taken
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	assign adv       = !v_s4 || res.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1 logic: validity, buffer indices, angles
	logic        cfg_ok;
	logic [6:0]  row7, col7;
	logic [11:0] top, rs, row_s, base;
	logic        pole_n, pole_s, vtx_ok;
	logic        cap_n, cap_s, tri_ok;
	logic [11:0] vidx, ta, tb, tc, i0, i1, i3;
	logic [21:0] th_prod, ph_prod;
	carry_t      carry_d;

	always_comb begin
		cfg_ok = (segments_q >= 7'd3) && (rings_q >= 7'd3)
			&& (32'(segments_q) <= MAX_SEGMENTS) && (32'(rings_q) <= MAX_RINGS);
		row7   = {1'b0, req.row};
		col7   = {1'b0, req.column};
		top    = 12'((rings_q - 7'd2) * segments_q);
		rs     = 12'((req.row - 6'd1) * segments_q);
		row_s  = rs + 12'(segments_q);
		base   = top - 12'(segments_q);

		pole_n = (req.row == 6'd0);
		pole_s = (row7 == rings_q - 7'd1);
		vtx_ok = cfg_ok && (row7 < rings_q) && (col7 < segments_q)
			&& (!(pole_n || pole_s) || req.column == 6'd0);
		if (pole_n)
			vidx = top;
		else if (pole_s)
			vidx = top + 12'd1;
		else
			vidx = rs + 12'(req.column);

		cap_n  = (req.row == 6'd0);
		cap_s  = (row7 == rings_q - 7'd2);
		tri_ok = cfg_ok && (row7 <= rings_q - 7'd2) && (col7 < segments_q - 7'd1)
			&& !((cap_n || cap_s) && req.half);
		i0 = rs + 12'(req.column);
		i1 = row_s + 12'(req.column) + 12'd1;
		i3 = row_s + 12'(req.column);
		if (cap_n) begin
			ta = top;
			tb = 12'(req.column);
			tc = 12'(req.column) + 12'd1;
		end else if (cap_s) begin
			ta = top + 12'd1;
			tb = base + 12'(req.column) + 12'd1;
			tc = base + 12'(req.column);
		end else begin
			ta = i0;
			tb = req.half ? i3 : i1;
			tc = req.half ? i1 : i0 + 12'd1;
		end

		carry_d = '0;
		if (req.operation == OP_VERTEX) begin
			carry_d.valid_res    = vtx_ok;
			carry_d.vert         = vtx_ok;
			carry_d.pole_n       = pole_n;
			carry_d.pole_s       = pole_s;
			carry_d.vertex_index = vtx_ok ? vidx : 12'd0;
		end else if (tri_ok) begin
			carry_d.valid_res = 1'b1;
			carry_d.tri_a     = ta;
			carry_d.tri_b     = tb;
			carry_d.tri_c     = tc;
		end

		th_prod = req.row * theta_step_q;
		ph_prod = req.column * phi_step_q;
	end

	carry_t             carry_s1, carry_s2, carry_s3, carry_s4;
	logic [SINE_AW-1:0] th_idx_s1, ph_idx_s1;
	logic signed [15:0] st_s2, ct_s2, sp_s2, cp_s2;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	logic signed [16:0] px_s4, py_s4, pz_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;

	localparam logic [SINE_AW-1:0] QUARTER = SINE_AW'(SINE_TABLE_DEPTH / 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			carry_s1  <= carry_d;
			th_idx_s1 <= th_prod[15 -: SINE_AW];
			ph_idx_s1 <= ph_prod[15 -: SINE_AW];
			// stage 2: sine and cosine reads
			carry_s2 <= carry_s1;
			st_s2    <= SINE_TAB[th_idx_s1];
			ct_s2    <= SINE_TAB[th_idx_s1 + QUARTER];
			sp_s2    <= SINE_TAB[ph_idx_s1];
			cp_s2    <= SINE_TAB[ph_idx_s1 + QUARTER];
			// stage 3: unit normal
			carry_s3 <= carry_s2;
			if (!carry_s2.vert) begin
				nx_s3 <= '0;
				ny_s3 <= '0;
				nz_s3 <= '0;
			end else if (carry_s2.pole_n || carry_s2.pole_s) begin
				nx_s3 <= '0;
				ny_s3 <= carry_s2.pole_n ? NORM_ONE : -NORM_ONE;
				nz_s3 <= '0;
			end else begin
				nx_s3 <= 16'(round_away(34'(st_s2 * cp_s2), 14));
				ny_s3 <= ct_s2;
				nz_s3 <= 16'(-round_away(34'(st_s2 * sp_s2), 14));
			end
			// stage 4: position
			carry_s4 <= carry_s3;
			nx_s4    <= nx_s3;
			ny_s4    <= ny_s3;
			nz_s4    <= nz_s3;
			px_s4    <= 17'(round_away(34'($signed({1'b0, radius_q}) * nx_s3), 14));
			py_s4    <= 17'(round_away(34'($signed({1'b0, radius_q}) * ny_s3), 14));
			pz_s4    <= 17'(round_away(34'($signed({1'b0, radius_q}) * nz_s3), 14));
		end
	end

	assign res.valid        = v_s4;
	assign res.valid_res    = carry_s4.valid_res;
	assign res.vertex_index = carry_s4.vertex_index;
	assign res.pos_x        = px_s4;
	assign res.pos_y        = py_s4;
	assign res.pos_z        = pz_s4;
	assign res.norm_x       = nx_s4;
	assign res.norm_y       = ny_s4;
	assign res.norm_z       = nz_s4;
	assign res.tri_index_a  = carry_s4.tri_a;
	assign res.tri_index_b  = carry_s4.tri_b;
	assign res.tri_index_c  = carry_s4.tri_c;

	// an invalid element returns all fields zero
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.valid_res |-> res.vertex_index == 12'd0 && res.pos_x == 17'sd0
		&& res.pos_y == 17'sd0 && res.norm_y == 16'sd0 && res.tri_index_a == 12'd0)
		else $error("invalid result with nonzero fields");

	// vertex and triangle fields never both carry data
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.tri_index_a != 12'd0 || res.tri_index_b != 12'd0)
		|-> res.norm_x == 16'sd0 && res.norm_y == 16'sd0 && res.norm_z == 16'sd0)
		else $error("triangle result with normal data");

	// x and y normal components stay within unit range
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.norm_y <= NORM_ONE && res.norm_y >= -NORM_ONE
		&& res.norm_x <= NORM_ONE && res.norm_x >= -NORM_ONE)
		else $error("normal out of unit range");

	// an item in stage 3 reaches the output stage when the pipe advances
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && adv |=> v_s4)
		else $error("item lost between stages");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top
	import uvs_pkg::*;
();

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_MAX  = 10;
	localparam longint unsigned Q30_UNIT    = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic               valid_res;
		logic        [11:0] vertex_index;
		logic signed [16:0] pos_x;
		logic signed [16:0] pos_y;
		logic signed [16:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic        [11:0] tri_index_a;
		logic        [11:0] tri_index_b;
		logic        [11:0] tri_index_c;
	} sphere_elem_t;

	// typed = 1: want holds the result, else the element predictor supplies it
	typedef struct packed {
		logic         op;
		logic [5:0]   row;
		logic [5:0]   col;
		logic         half;
		logic         typed;
		sphere_elem_t want;
	} probe_t;

	localparam int N_PROBES = 25;

	// written for the reset shape: 32 segments, 16 rings, radius 1.0
	localparam probe_t PROBES [N_PROBES] = '{
		'{OP_VERTEX, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b1, 12'd448, 17'sd0, 17'sd4096, 17'sd0,
			16'sd0, NORM_ONE, 16'sd0, 12'd0, 12'd0, 12'd0}},
		'{OP_VERTEX, 6'd15, 6'd0, 1'b0, 1'b1, '{1'b1, 12'd449, 17'sd0, -17'sd4096, 17'sd0,
			16'sd0, -NORM_ONE, 16'sd0, 12'd0, 12'd0, 12'd0}},
		'{OP_VERTEX, 6'd0, 6'd1, 1'b0, 1'b1, '0},
		'{OP_VERTEX, 6'd15, 6'd31, 1'b1, 1'b1, '0},
		'{OP_VERTEX, 6'd16, 6'd0, 1'b0, 1'b1, '0},
		'{OP_VERTEX, 6'd63, 6'd63, 1'b1, 1'b1, '0},
		'{OP_VERTEX, 6'd1, 6'd32, 1'b0, 1'b1, '0},
		'{OP_VERTEX, 6'd1, 6'd0, 1'b0, 1'b0, '0},
		'{OP_VERTEX, 6'd1, 6'd31, 1'b0, 1'b0, '0},
		'{OP_VERTEX, 6'd14, 6'd31, 1'b1, 1'b0, '0},
		'{OP_VERTEX, 6'd8, 6'd16, 1'b0, 1'b0, '0},
		'{OP_VERTEX, 6'd7, 6'd8, 1'b0, 1'b0, '0},
		'{OP_TRIANGLE, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd448, 12'd0, 12'd1}},
		'{OP_TRIANGLE, 6'd0, 6'd30, 1'b0, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd448, 12'd30, 12'd31}},
		'{OP_TRIANGLE, 6'd0, 6'd0, 1'b1, 1'b1, '0},
		'{OP_TRIANGLE, 6'd14, 6'd0, 1'b0, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd449, 12'd417, 12'd416}},
		'{OP_TRIANGLE, 6'd14, 6'd30, 1'b0, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd449, 12'd447, 12'd446}},
		'{OP_TRIANGLE, 6'd14, 6'd5, 1'b1, 1'b1, '0},
		'{OP_TRIANGLE, 6'd1, 6'd0, 1'b0, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd33, 12'd1}},
		'{OP_TRIANGLE, 6'd1, 6'd0, 1'b1, 1'b1, '{1'b1, 12'd0, 17'sd0, 17'sd0, 17'sd0,
			16'sd0, 16'sd0, 16'sd0, 12'd0, 12'd32, 12'd33}},
		'{OP_TRIANGLE, 6'd13, 6'd30, 1'b1, 1'b0, '0},
		'{OP_TRIANGLE, 6'd15, 6'd0, 1'b0, 1'b1, '0},
		'{OP_TRIANGLE, 6'd5, 6'd31, 1'b0, 1'b1, '0},
		'{OP_TRIANGLE, 6'd63, 6'd63, 1'b1, 1'b1, '0},
		'{OP_TRIANGLE, 6'd7, 6'd12, 1'b0, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	uvs_cfg_if cfg_bus ();
	uvs_req_if req_bus ();
	uvs_res_if res_bus ();

	uv_sphere_vertex_and_index_gen_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.res    (res_bus)
	);

	// shape registers as the block should hold them
	logic [6:0]  cfg_seg    = 7'd32;
	logic [6:0]  cfg_rings  = 7'd16;
	logic [15:0] cfg_radius = 16'd4096;
	logic [15:0] cfg_theta  = 16'd2185;
	logic [15:0] cfg_phi    = 16'd2114;

	int sine_lut [SINE_TABLE_DEPTH];
	sphere_elem_t elems_due [$];

	int offer_gap_pct;
	int take_gap_pct;
	int hold_asks;
	int holds_done;
	int unsigned cycle_count;
	int mismatches;
	int n_sent;
	int n_vertex;
	int n_triangle;
	int n_rejected;
	int n_shapes;
	sphere_elem_t got_elem;
	sphere_elem_t want_elem;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// quarter-wave fold, taylor series to x^11 in q30, rounded to q14
	function automatic int sine_q14(int k);
		longint unsigned quad, rem, x, x2, t, s, m;
		quad = longint'(k) * 4 / SINE_TABLE_DEPTH;
		rem  = longint'(k) * 4 - quad * SINE_TABLE_DEPTH;
		if (quad[0])
			rem = SINE_TABLE_DEPTH - rem;
		x  = rem * HALF_PI_Q30 / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t  = Q30_UNIT - x2 / 110;
		t  = Q30_UNIT - ((x2 * t) >> 30) / 72;
		t  = Q30_UNIT - ((x2 * t) >> 30) / 42;
		t  = Q30_UNIT - ((x2 * t) >> 30) / 20;
		t  = Q30_UNIT - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		m  = (s + 32768) >> 16;
		if (m > 16384)
			m = 16384;
		return (quad >= 2) ? -int'(m) : int'(m);
	endfunction

	function automatic longint sine_turns(logic [15:0] a);
		return sine_lut[(int'(a) * SINE_TABLE_DEPTH) >> 16];
	endfunction

	function automatic longint round_q14(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + 8192) >>> 14;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic sphere_elem_t predict_elem(logic op, logic [5:0] rw, logic [5:0] cl,
			logic hf);
		sphere_elem_t e;
		int s, r, top, base, j;
		longint st, ct, sp, cp, nx, ny, nz;
		logic [15:0] th, ph;
		e = '0;
		s = cfg_seg;
		r = cfg_rings;
		if (s < 3 || r < 3 || s > MAX_SEGMENTS || r > MAX_RINGS)
			return e;
		top = (r - 2) * s;
		if (op == OP_VERTEX) begin
			if (rw >= r || cl >= s)
				return e;
			if (rw == 0 || rw == r - 1) begin
				if (cl != 0)
					return e;
				e.vertex_index = (rw == 0) ? top : top + 1;
				nx = 0;
				ny = (rw == 0) ? 16384 : -16384;
				nz = 0;
			end else begin
				th = 16'(int'(rw) * int'(cfg_theta));
				ph = 16'(int'(cl) * int'(cfg_phi));
				st = sine_turns(th);
				ct = sine_turns(th + 16'd16384);
				sp = sine_turns(ph);
				cp = sine_turns(ph + 16'd16384);
				e.vertex_index = (rw - 1) * s + cl;
				nx = round_q14(st * cp);
				ny = ct;
				nz = -round_q14(st * sp);
			end
			e.valid_res = 1'b1;
			e.norm_x = nx;
			e.norm_y = ny;
			e.norm_z = nz;
			e.pos_x = round_q14(longint'(cfg_radius) * nx);
			e.pos_y = round_q14(longint'(cfg_radius) * ny);
			e.pos_z = round_q14(longint'(cfg_radius) * nz);
		end else begin
			if (rw > r - 2 || cl >= s - 1)
				return e;
			if (rw == 0) begin
				if (hf)
					return e;
				e.tri_index_a = top;
				e.tri_index_b = cl;
				e.tri_index_c = cl + 1;
			end else if (rw == r - 2) begin
				if (hf)
					return e;
				base = (r - 3) * s;
				e.tri_index_a = top + 1;
				e.tri_index_b = base + cl + 1;
				e.tri_index_c = base + cl;
			end else begin
				// interior quad split along the i0-i1 diagonal
				j = rw - 1;
				e.tri_index_a = j * s + cl;
				e.tri_index_b = hf ? (j + 1) * s + cl : (j + 1) * s + cl + 1;
				e.tri_index_c = hf ? (j + 1) * s + cl + 1 : j * s + cl + 1;
			end
			e.valid_res = 1'b1;
		end
		return e;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_SEGMENTS:   cfg_seg = value[6:0];
			REG_RINGS:      cfg_rings = value[6:0];
			REG_RADIUS:     cfg_radius = value;
			REG_THETA_STEP: cfg_theta = value;
			REG_PHI_STEP:   cfg_phi = value;
			default: ;
		endcase
	endtask

	task automatic set_shape(logic [15:0] seg, logic [15:0] rng, logic [15:0] rad,
			logic [15:0] th, logic [15:0] ph);
		write_reg(REG_SEGMENTS, seg);
		write_reg(REG_RINGS, rng);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_THETA_STEP, th);
		write_reg(REG_PHI_STEP, ph);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		n_shapes++;
	endtask

	task automatic send_req(logic op, logic [5:0] rw, logic [5:0] cl, logic hf,
			logic typed, sphere_elem_t want);
		@(negedge clk);
		while ($urandom_range(99) < offer_gap_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.operation <= op;
		req_bus.row       <= rw;
		req_bus.column    <= cl;
		req_bus.half      <= hf;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		elems_due = {elems_due, (typed ? want : predict_elem(op, rw, cl, hf))};
		n_sent++;
	endtask

	// mostly well-formed requests for the current shape, the rest raw noise
	task automatic send_random();
		logic op, hf;
		int s, r, rw, cl;
		s = cfg_seg;
		r = cfg_rings;
		op = $urandom_range(1);
		hf = $urandom_range(1);
		if ($urandom_range(99) < 15 || s < 3 || r < 3 || s > MAX_SEGMENTS
				|| r > MAX_RINGS) begin
			rw = $urandom_range(63);
			cl = $urandom_range(63);
		end else if (op == OP_VERTEX) begin
			rw = $urandom_range(r - 1);
			cl = (rw == 0 || rw == r - 1) ? 0 : $urandom_range(s - 1);
		end else begin
			rw = $urandom_range(r - 2);
			cl = $urandom_range(s - 2);
			if (rw == 0 || rw == r - 2)
				hf = 1'b0;
		end
		send_req(op, 6'(rw), 6'(cl), hf, 1'b0, '0);
	endtask

	task automatic run_random(int n_items, bit with_hold);
		if (with_hold)
			hold_asks++;
		repeat (n_items)
			send_random();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (elems_due.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls plus one long hold-off per run that asks for it
	initial begin
		res_bus.ready = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			res_bus.ready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got_elem = '{res_bus.valid_res, res_bus.vertex_index,
				res_bus.pos_x, res_bus.pos_y, res_bus.pos_z,
				res_bus.norm_x, res_bus.norm_y, res_bus.norm_z,
				res_bus.tri_index_a, res_bus.tri_index_b, res_bus.tri_index_c};
			if (elems_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result transfer at cycle %0d", cycle_count);
			end else begin
				want_elem = elems_due.pop_front();
				if (!want_elem.valid_res)
					n_rejected++;
				else if ((want_elem.tri_index_a | want_elem.tri_index_b
						| want_elem.tri_index_c) != 0)
					n_triangle++;
				else
					n_vertex++;
				if (got_elem !== want_elem) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  want ok=%0b vi=%0d pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) tri=(%0d,%0d,%0d)",
							want_elem.valid_res, want_elem.vertex_index,
							want_elem.pos_x, want_elem.pos_y, want_elem.pos_z,
							want_elem.norm_x, want_elem.norm_y, want_elem.norm_z,
							want_elem.tri_index_a, want_elem.tri_index_b,
							want_elem.tri_index_c);
						$display("  got  ok=%0b vi=%0d pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) tri=(%0d,%0d,%0d)",
							got_elem.valid_res, got_elem.vertex_index,
							got_elem.pos_x, got_elem.pos_y, got_elem.pos_z,
							got_elem.norm_x, got_elem.norm_y, got_elem.norm_z,
							got_elem.tri_index_a, got_elem.tri_index_b,
							got_elem.tri_index_c);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				elems_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int i, s, r;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.operation = OP_VERTEX;
		req_bus.row = 6'd0;
		req_bus.column = 6'd0;
		req_bus.half = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_SEGMENTS;
		cfg_bus.data = 16'd0;
		hold_asks = 0;
		cycle_count = 0;
		mismatches = 0;
		n_sent = 0;
		n_vertex = 0;
		n_triangle = 0;
		n_rejected = 0;
		n_shapes = 1;
		for (i = 0; i < SINE_TABLE_DEPTH; i++)
			sine_lut[i] = sine_q14(i);
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer_gap_pct = 30;
		take_gap_pct = 72;
		for (i = 0; i < N_PROBES; i++)
			send_req(PROBES[i].op, PROBES[i].row, PROBES[i].col, PROBES[i].half,
				PROBES[i].typed, PROBES[i].want);
		run_random(300, 1'b1);
		// smallest sphere, full radius; upper data bits of segments must be dropped
		set_shape(16'hFF83, 16'd3, 16'hFFFF, 16'h8000, 16'd21845);
		run_random(250, 1'b0);

		offer_gap_pct = 72;
		take_gap_pct = 30;
		set_shape(16'd64, 16'd64, 16'd0, 16'd1040, 16'd1040);
		run_random(250, 1'b0);
		set_shape(16'd64, 16'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(250, 1'b0);
		// out-of-range shapes reject every request
		set_shape(16'd2, 16'd64, 16'd4096, 16'd2185, 16'd2114);
		run_random(40, 1'b0);
		set_shape(16'd64, 16'd2, 16'd4096, 16'd2185, 16'd2114);
		run_random(40, 1'b0);
		set_shape(16'hFF7F, 16'd65, 16'd4096, 16'd2185, 16'd2114);
		run_random(40, 1'b0);

		offer_gap_pct = 0;
		take_gap_pct = 0;
		for (i = 0; i < 4; i++) begin
			s = $urandom_range(3, MAX_SEGMENTS);
			r = $urandom_range(3, MAX_RINGS);
			if ($urandom_range(1))
				set_shape(16'(s), 16'(r), 16'($urandom), 16'(32768 / (r - 1)),
					16'(65536 / (s - 1)));
			else
				set_shape(16'(s), 16'(r), 16'($urandom), 16'($urandom), 16'($urandom));
			run_random(150, i == 0);
		end

		while (elems_due.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		$display("%0d requests over %0d sphere shapes: %0d vertices, %0d triangles, %0d rejected",
			n_sent, n_shapes, n_vertex, n_triangle, n_rejected);
		$display("%0d mismatching or unexpected results", mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
